FILE: rtl/stk_pkg.sv
// Shared types and constants for the framed-message receiver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package stk_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_START_MARKER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TOKEN_MARKER = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SEQ_CHECK    = 2'd2;
  localparam int unsigned CfgDataW = 8;

  // Register reset values
  localparam logic [7:0] START_MARKER_RST = 8'd27;
  localparam logic [7:0] TOKEN_MARKER_RST = 8'd14;
  localparam logic       SEQ_CHECK_RST    = 1'b1;

  // Result queue depth
  localparam int unsigned QueueDepth = 4;

  // Input commands
  localparam logic CMD_RX_BYTE    = 1'b0;
  localparam logic CMD_REPLY_SENT = 1'b1;

  typedef enum logic [1:0] {
    KIND_BODY    = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_BAD_SUM = 2'd2,
    KIND_DISCARD = 2'd3
  } kind_e;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic        last;
    logic [7:0]  seq_number;
    logic [15:0] msg_length;
  } out_word_t;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] token_marker;
    logic       seq_check_enable;
  } cfg_t;

endpackage

FILE: rtl/stk_front.sv
// Front end: frame parser that classifies each accepted word into zero or
// one result word. Depends on stk_pkg.
`timescale 1ns / 1ps

module stk_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stk_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  input  stk_pkg::in_word_t in_word_i,
  output logic              ev_valid_o,
  output stk_pkg::out_word_t ev_word_o
);
  import stk_pkg::*;

  localparam logic [2:0] ST_WAIT   = 3'd0;
  localparam logic [2:0] ST_SEQ    = 3'd1;
  localparam logic [2:0] ST_LEN_HI = 3'd2;
  localparam logic [2:0] ST_LEN_LO = 3'd3;
  localparam logic [2:0] ST_TOKEN  = 3'd4;
  localparam logic [2:0] ST_BODY   = 3'd5;
  localparam logic [2:0] ST_CHECK  = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  exp_seq_q, exp_seq_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;

  logic [7:0]  c;
  logic [16:0] cnt_next;
  logic        is_last;

  assign c        = in_word_i.rx_byte;
  assign cnt_next = {1'b0, cnt_q} + 17'd1;
  assign is_last  = cnt_next >= {1'b0, len_q};

  always_comb begin
    state_d    = state_q;
    xor_d      = xor_q;
    exp_seq_d  = exp_seq_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    ev_valid_o = 1'b0;
    ev_word_o  = '{kind: KIND_BODY, data_byte: 8'd0, byte_index: 16'd0, last: 1'b0,
                   seq_number: exp_seq_q, msg_length: len_q};
    if (in_valid_i) begin
      if (in_word_i.command == CMD_REPLY_SENT) begin
        exp_seq_d = exp_seq_q + 8'd1;
      end else begin
        unique case (state_q)
          ST_SEQ: begin
            if (!cfg_i.seq_check_enable || c == 8'd1 || c == exp_seq_q) begin
              exp_seq_d = c;
              xor_d     = xor_q ^ c;
              state_d   = ST_LEN_HI;
            end else begin
              ev_valid_o           = 1'b1;
              ev_word_o.kind       = KIND_DISCARD;
              ev_word_o.seq_number = c;
              ev_word_o.msg_length = 16'd0;
              state_d              = ST_WAIT;
            end
          end
          ST_LEN_HI: begin
            len_d   = {c, 8'd0};
            xor_d   = xor_q ^ c;
            state_d = ST_LEN_LO;
          end
          ST_LEN_LO: begin
            len_d   = len_q | {8'd0, c};
            xor_d   = xor_q ^ c;
            state_d = ST_TOKEN;
          end
          ST_TOKEN: begin
            if (c == cfg_i.token_marker) begin
              xor_d   = xor_q ^ c;
              cnt_d   = 16'd0;
              state_d = ST_BODY;
            end else begin
              ev_valid_o     = 1'b1;
              ev_word_o.kind = KIND_DISCARD;
              state_d        = ST_WAIT;
            end
          end
          ST_BODY: begin
            xor_d                = xor_q ^ c;
            ev_valid_o           = 1'b1;
            ev_word_o.data_byte  = c;
            ev_word_o.byte_index = cnt_q;
            ev_word_o.last       = is_last;
            cnt_d                = cnt_next[15:0];
            if (is_last) begin
              state_d = ST_CHECK;
            end
          end
          ST_CHECK: begin
            ev_valid_o     = 1'b1;
            ev_word_o.kind = (c == xor_q) ? KIND_ACCEPT : KIND_BAD_SUM;
            state_d        = ST_WAIT;
          end
          default: begin
            // waiting for a start marker; unused codes land here too
            state_d = ST_WAIT;
            if (c == cfg_i.start_marker) begin
              xor_d   = cfg_i.start_marker;
              state_d = ST_SEQ;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_WAIT;
      xor_q     <= 8'd0;
      exp_seq_q <= 8'd0;
      len_q     <= 16'd0;
      cnt_q     <= 16'd0;
    end else begin
      state_q   <= state_d;
      xor_q     <= xor_d;
      exp_seq_q <= exp_seq_d;
      len_q     <= len_d;
      cnt_q     <= cnt_d;
    end
  end

endmodule

FILE: rtl/stk_queue.sv
// Back end: result queue between the parser and the consumer.
// Depends on stk_pkg for the result word type.
`timescale 1ns / 1ps

module stk_queue #(
  parameter int unsigned Depth = stk_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  stk_pkg::out_word_t wr_word_i,
  input  logic               rd_en_i,
  output stk_pkg::out_word_t rd_word_o,
  output logic               full_o,
  output logic               empty_o
);
  import stk_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  out_word_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o    = cnt_q == CntW'(Depth);
  assign empty_o   = cnt_q == '0;
  assign rd_word_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!wr_en_i && rd_en_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: rtl/stk500v2_frame_receiver.sv
// Top level of the framed-message receiver: config registers, parser front
// end and result queue. Depends on stk_pkg, stk_front and stk_queue.
//  - Input side looks like a queue: drive in_word_i and raise push; the word
//    is taken on a rising edge with push high and full low. A word is a
//    received byte (command 0) or a reply-sent note (command 1) that bumps
//    the expected sequence number.
//  - Result side looks like a queue: while empty is low the oldest result
//    word sits on out_word_o; raise pop to take it.
//  - Each accepted word yields zero or one result: a body byte with its
//    index and last mark, frame accepted, checksum mismatch, or discard.
//  - A result enters the queue on the edge that takes its input word and
//    shows on out_word_o once older results are popped. Throughput: one
//    word per cycle while full is low; the parser never stalls on its own.
//  - Stall: with pop held off, results collect in a QueueDepth-word queue;
//    while it is full, full is high and input waits. Full drops the cycle
//    after a pop frees a slot.
//  - Config: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at once
//    (0 start, 1 token, 2 sequence check in bit 0). Write only while idle.
//  - Reset (rst_ni low, async): parser waits for a start marker, state
//    clears, queue empties, registers return to 27, 14 and 1.
`timescale 1ns / 1ps

module stk500v2_frame_receiver #(
  parameter int unsigned QueueDepth = stk_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          push,
  output logic                          full,
  input  stk_pkg::in_word_t             in_word_i,
  // result channel
  output logic                          empty,
  input  logic                          pop,
  output stk_pkg::out_word_t            out_word_o,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [stk_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [stk_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import stk_pkg::*;

  cfg_t      cfg_q;
  logic      in_take;
  logic      ev_valid;
  out_word_t ev_word;
  logic      q_full;
  logic      q_empty;

  // config registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker     <= START_MARKER_RST;
      cfg_q.token_marker     <= TOKEN_MARKER_RST;
      cfg_q.seq_check_enable <= SEQ_CHECK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_MARKER: cfg_q.start_marker     <= cfg_wdata_i;
        CFG_TOKEN_MARKER: cfg_q.token_marker     <= cfg_wdata_i;
        CFG_SEQ_CHECK:    cfg_q.seq_check_enable <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign in_take = push && !q_full;

  // parser: classifies each taken word in the same cycle
  stk_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_take),
    .in_word_i  (in_word_i),
    .ev_valid_o (ev_valid),
    .ev_word_o  (ev_word)
  );

  // result queue decouples the parser from the consumer
  stk_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (ev_valid),
    .wr_word_i (ev_word),
    .rd_en_i   (pop && !q_empty),
    .rd_word_o (out_word_o),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  assign full  = q_full;
  assign empty = q_empty;

endmodule
